/* sv/fsbt_pkg.sv */
package fsbt_pkg;

	localparam int MAX_BYTES  = 16;
	localparam int IDX_W      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CNT_W      = $clog2(MAX_BYTES + 1);
	localparam int FRAME_BITS = 14;
	localparam int FB_W       = $clog2(FRAME_BITS);
	localparam int TPB_W      = 16;
	localparam logic [TPB_W-1:0] TPB_RESET = 16'd1000;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_TICKS_PER_BIT = 1'b0;

	// one accepted input beat, as seen by the datapath
	typedef struct packed {
		logic       tick;
		logic       load;
		logic [7:0] data;
		logic       last;
	} fsbt_cmd_t;

	// one result beat
	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic dropped;
	} fsbt_res_t;

	// frame sent msb first: 0 0 1 0 b7 b6 b5 b4 /b4 b3 b2 b1 b0 /b0
	function automatic logic [FRAME_BITS-1:0] fsbt_frame(input logic [7:0] d);
		fsbt_frame = {3'b001, 1'b0, d[7:4], ~d[4], d[3:0], ~d[0]};
	endfunction

endpackage

/* sv/fsbt_if.sv */
interface fsbt_in_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [0:0] op;
	logic [7:0] data_byte;
	logic [0:0] last_byte;

	modport source (output valid, op, data_byte, last_byte, input ready);
	modport sink (input valid, op, data_byte, last_byte, output ready);
endinterface

interface fsbt_out_if (input logic clk);
	logic       valid;
	logic       ready;
	logic [0:0] line_level;
	logic [0:0] busy_res;
	logic [0:0] dropped;

	modport source (output valid, line_level, busy_res, dropped, input ready);
	modport sink (input valid, line_level, busy_res, dropped, output ready);
endinterface

/* sv/framed_serial_byte_transmitter.sv */
// framed serial byte transmitter
// in_ch beats are either a tick (op 0) or a program byte load (op 1). loads
// fill a 16-entry byte buffer; a load with last_byte set starts sending all
// held bytes. each byte goes out msb first as a 14-bit frame
// (0 0 1 0 b7 b6 b5 b4 /b4 b3 b2 b1 b0 /b0), each bit held for ticks_per_bit
// tick beats. the frame sits in a shift register that moves one bit per bit
// time, so the datapath stays one bit wide.
// every in_ch beat yields exactly one out_ch beat: line level after the beat,
// busy flag, and a dropped flag for loads refused while busy or when full.
// the result is registered at the accepting edge and shows on out_ch the next
// cycle. one beat per cycle is sustained while out_ch keeps ready high; the
// single output register is the only storage between the two sides.
// when out_ch stalls, in_ch.ready drops as soon as the output register is
// full and the held result stays until taken.
// ticks_per_bit is an apb register at byte address 0 (reset 1000); write it
// only while idle.
// arst_n clears the counters, idle state, line low and the output valid flag;
// the byte buffer itself is not cleared and needs no clearing pass.
module framed_serial_byte_transmitter (
	input  logic                          clk,
	input  logic                          arst_n,
	fsbt_in_if.sink                       in_ch,
	fsbt_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fsbt_pkg::PADDR_W-1:0]  paddr,
	input  logic [fsbt_pkg::PDATA_W-1:0]  pwdata,
	output logic [fsbt_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import fsbt_pkg::*;

	logic             fire;
	fsbt_cmd_t        cmd;
	fsbt_res_t        res;
	logic             sending;
	logic             start;
	logic             bit_adv;
	logic [TPB_W-1:0] tpb_q;
	logic             out_valid_q;
	fsbt_res_t        out_q;
	logic             reg_hit;

	// apb register file: one register, zero wait states
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_TICKS_PER_BIT);
	assign prdata  = reg_hit ? PDATA_W'(tpb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q <= TPB_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			tpb_q <= pwdata[TPB_W-1:0];
		end
	end

	// take a new beat whenever the output register is free or being drained
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;

	assign cmd.tick = (in_ch.op == 1'b0);
	assign cmd.load = (in_ch.op == 1'b1);
	assign cmd.data = in_ch.data_byte;
	assign cmd.last = in_ch.last_byte[0];

	fsbt_bit_timer u_timer (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.fire          (fire),
		.sending       (sending),
		.start         (start),
		.ticks_per_bit (tpb_q),
		.bit_adv       (bit_adv)
	);

	fsbt_frame_shifter u_shifter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.fire    (fire),
		.bit_adv (bit_adv),
		.sending (sending),
		.start   (start),
		.res     (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.line_level = out_q.line_level;
	assign out_ch.busy_res   = out_q.busy_res;
	assign out_ch.dropped    = out_q.dropped;
endmodule

/* sv/fsbt_bit_timer.sv */
module fsbt_bit_timer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fsbt_pkg::fsbt_cmd_t       cmd,
	input  logic                      fire,
	input  logic                      sending,
	input  logic                      start,
	input  logic [fsbt_pkg::TPB_W-1:0] ticks_per_bit,
	output logic                      bit_adv
);
	import fsbt_pkg::*;

	logic [TPB_W-1:0] tick_count_q;
	logic [TPB_W-1:0] cnt_inc;
	logic             tick_en;

	assign tick_en = fire && cmd.tick && sending;
	assign cnt_inc = tick_count_q + 1'b1;
	// a zero period compares as always reached, so it behaves like one
	assign bit_adv = tick_en && (cnt_inc >= ticks_per_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (fire && start) begin
			tick_count_q <= '0;
		end else if (tick_en) begin
			tick_count_q <= bit_adv ? '0 : cnt_inc;
		end
	end
endmodule

/* sv/fsbt_frame_shifter.sv */
module fsbt_frame_shifter (
	input  logic                clk,
	input  logic                arst_n,
	input  fsbt_pkg::fsbt_cmd_t cmd,
	input  logic                fire,
	input  logic                bit_adv,
	output logic                sending,
	output logic                start,
	output fsbt_pkg::fsbt_res_t res
);
	import fsbt_pkg::*;

	logic [7:0]            store_q [MAX_BYTES];
	logic [CNT_W-1:0]      total_q, total_d;
	logic [CNT_W-1:0]      pos_q, pos_d;
	logic [CNT_W-1:0]      pos_inc;
	logic [FB_W-1:0]       fbit_q, fbit_d;
	logic [FRAME_BITS-1:0] frame_q, frame_d;
	logic                  sending_q, sending_d;
	logic                  room;
	logic                  wr_en;
	logic                  drop;
	logic [7:0]            start_byte;

	assign sending    = sending_q;
	assign room       = (total_q < CNT_W'(MAX_BYTES));
	assign wr_en      = cmd.load && !sending_q && room;
	// start needs at least one byte held after this load
	assign start      = cmd.load && !sending_q && cmd.last && (room || (total_q != '0));
	assign start_byte = (total_q == '0) ? cmd.data : store_q[0];
	assign pos_inc    = pos_q + 1'b1;

	always_comb begin
		total_d   = total_q;
		pos_d     = pos_q;
		fbit_d    = fbit_q;
		frame_d   = frame_q;
		sending_d = sending_q;
		drop      = 1'b0;
		if (cmd.tick) begin
			if (bit_adv) begin
				if (fbit_q == FB_W'(FRAME_BITS - 1)) begin
					fbit_d = '0;
					if (pos_inc >= total_q) begin
						sending_d = 1'b0;
						pos_d     = '0;
						total_d   = '0;
						frame_d   = '0;
					end else begin
						pos_d   = pos_inc;
						frame_d = fsbt_frame(store_q[pos_inc[IDX_W-1:0]]);
					end
				end else begin
					fbit_d  = fbit_q + 1'b1;
					frame_d = {frame_q[FRAME_BITS-2:0], 1'b0};
				end
			end
		end else if (cmd.load) begin
			if (sending_q) begin
				drop = 1'b1;
			end else begin
				if (room) begin
					total_d = total_q + 1'b1;
				end else begin
					drop = 1'b1;
				end
				if (start) begin
					pos_d     = '0;
					fbit_d    = '0;
					sending_d = 1'b1;
					frame_d   = fsbt_frame(start_byte);
				end
			end
		end
	end

	assign res.line_level = sending_d && frame_d[FRAME_BITS-1];
	assign res.busy_res   = sending_d;
	assign res.dropped    = drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			pos_q     <= '0;
			fbit_q    <= '0;
			frame_q   <= '0;
			sending_q <= 1'b0;
		end else if (fire) begin
			total_q   <= total_d;
			pos_q     <= pos_d;
			fbit_q    <= fbit_d;
			frame_q   <= frame_d;
			sending_q <= sending_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en) begin
			store_q[total_q[IDX_W-1:0]] <= cmd.data;
		end
	end
endmodule

/* sv/fsbt_checker.sv */
module fsbt_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic line_level,
	input logic busy_res,
	input logic dropped
);
	// line is low whenever nothing is being sent
	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> !line_level)
		else $error("line high while idle");

	// an empty output register always takes a new beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// each accepted beat produces a result beat next cycle
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted beat produced no result");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line_level)
			&& $stable(busy_res) && $stable(dropped))
		else $error("stalled result changed");
endmodule

bind framed_serial_byte_transmitter fsbt_checker u_fsbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.line_level (out_ch.line_level[0]),
	.busy_res   (out_ch.busy_res[0]),
	.dropped    (out_ch.dropped[0])
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import fsbt_pkg::*;

	// beat kinds on the input channel
	typedef enum bit {
		OP_TICK = 1'b0,
		OP_LOAD = 1'b1
	} beat_op_e;

	// one pending input beat
	typedef struct {
		beat_op_e   op;
		logic [7:0] data;
		logic       last;
	} prog_beat_t;

	localparam int RANDOM_BEATS     = 1100;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int WATCHDOG_CYCLES  = 2000;
	localparam int MAX_PRINTED      = 100;
	localparam logic [PADDR_W-1:0] TPB_ADDR = PADDR_W'(4 * REG_TICKS_PER_BIT);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// apb side, idle from time zero
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	fsbt_in_if  in_if (.clk(clk));
	fsbt_out_if out_if (.clk(clk));

	framed_serial_byte_transmitter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_if),
		.out_ch  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// beats waiting for the driver, and line results still owed by the block
	prog_beat_t pending_beats[$];
	fsbt_res_t  line_results_due[$];

	int beats_queued = 0;
	int beats_taken  = 0;
	int err_count    = 0;
	int quiet_cycles = 0;
	bit in_taken     = 1'b0;

	// idling controls, shared between the stimulus and the two side processes
	int src_gap_pct   = 0;
	int snk_stall_pct = 0;
	int gap_left      = 0;
	int stall_left    = 0;
	int hold_left     = 0;
	bit hold_request  = 1'b0;

	// transmitter state as the testbench sees it
	logic [7:0]       prog_bytes [MAX_BYTES];
	logic [CNT_W-1:0] held_count = '0;
	logic [CNT_W-1:0] send_idx   = '0;
	logic [FB_W-1:0]  bit_pos    = '0;
	logic [TPB_W-1:0] tick_cnt   = '0;
	logic [TPB_W-1:0] bit_ticks  = TPB_RESET;
	logic             tx_active  = 1'b0;
	logic             line_q     = 1'b0;

	// every input of the block known from the start
	initial begin
		in_if.valid     = 1'b0;
		in_if.op        = '0;
		in_if.data_byte = '0;
		in_if.last_byte = '0;
		out_if.ready    = 1'b0;
	end

	task automatic report_mismatch(string what);
		if (err_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, what);
		err_count++;
	endtask

	// line level at frame position k, msb of the byte first
	function automatic logic frame_level(logic [7:0] d, int k);
		case (k)
			2: return 1'b1;
			4, 5, 6, 7: return d[11 - k];
			8: return ~d[4];
			9, 10, 11, 12: return d[12 - k];
			13: return ~d[0];
			default: return 1'b0;
		endcase
	endfunction

	function automatic void refresh_line();
		if (tx_active && send_idx < held_count && send_idx < MAX_BYTES)
			line_q = frame_level(prog_bytes[send_idx[IDX_W-1:0]], int'(bit_pos));
		else
			line_q = 1'b0;
	endfunction

	// advance the transmitter by one beat and give the result it owes
	function automatic fsbt_res_t step_transmitter(beat_op_e op, logic [7:0] d, logic last);
		fsbt_res_t r;
		r.dropped = 1'b0;
		if (op == OP_TICK) begin
			// ticks while idle change nothing
			if (tx_active) begin
				tick_cnt = tick_cnt + 1'b1;
				// a bit time of zero behaves as one
				if (tick_cnt >= bit_ticks) begin
					tick_cnt = '0;
					bit_pos  = bit_pos + 1'b1;
					if (bit_pos >= FRAME_BITS) begin
						bit_pos  = '0;
						send_idx = send_idx + 1'b1;
						// last frame done: back to an empty program
						if (send_idx >= held_count) begin
							tx_active  = 1'b0;
							send_idx   = '0;
							held_count = '0;
						end
					end
				end
				refresh_line();
			end
		end else if (tx_active) begin
			// load while sending is refused
			r.dropped = 1'b1;
		end else begin
			if (held_count < MAX_BYTES) begin
				prog_bytes[held_count[IDX_W-1:0]] = d;
				held_count = held_count + 1'b1;
			end else begin
				// buffer full, byte lost, but a last flag still starts the send
				r.dropped = 1'b1;
			end
			if (last && held_count != 0) begin
				send_idx  = '0;
				bit_pos   = '0;
				tick_cnt  = '0;
				tx_active = 1'b1;
				refresh_line();
			end
		end
		r.line_level = line_q;
		r.busy_res   = tx_active;
		return r;
	endfunction

	// monitor: predict on accepted input beats, check accepted output beats
	always @(posedge clk) begin
		fsbt_res_t due;
		in_taken = in_if.valid && in_if.ready && arst_n;
		if (in_taken) begin
			line_results_due.push_back(step_transmitter(beat_op_e'(in_if.op),
				in_if.data_byte, in_if.last_byte));
			beats_taken++;
		end
		if (arst_n && out_if.valid && out_if.ready) begin
			if (line_results_due.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				due = line_results_due.pop_front();
				if (out_if.line_level !== due.line_level)
					report_mismatch($sformatf("line_level %b, expected %b",
						out_if.line_level, due.line_level));
				if (out_if.busy_res !== due.busy_res)
					report_mismatch($sformatf("busy_res %b, expected %b",
						out_if.busy_res, due.busy_res));
				if (out_if.dropped !== due.dropped)
					report_mismatch($sformatf("dropped %b, expected %b",
						out_if.dropped, due.dropped));
			end
		end
		// watchdog bookkeeping
		if (in_taken || (out_if.valid && out_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// driver: holds a beat until taken, otherwise idles in bursts or sends the next one
	always @(negedge clk) begin
		prog_beat_t b;
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else if (in_if.valid && !in_taken) begin
			// beat still offered, keep it
		end else if (gap_left > 0) begin
			gap_left--;
			in_if.valid <= 1'b0;
		end else if (pending_beats.size() > 0 && src_gap_pct > 0 &&
				$urandom_range(0, 99) < src_gap_pct) begin
			gap_left = $urandom_range(1, 8) - 1;
			in_if.valid <= 1'b0;
		end else if (pending_beats.size() > 0) begin
			b = pending_beats.pop_front();
			in_if.valid     <= 1'b1;
			in_if.op        <= b.op;
			in_if.data_byte <= b.data;
			in_if.last_byte <= b.last;
		end else begin
			in_if.valid <= 1'b0;
		end
	end

	// receiver: long hold on request, else random stall bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_if.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = LONG_HOLD_CYCLES - 1;
			out_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_if.ready <= 1'b0;
		end else if (snk_stall_pct > 0 && $urandom_range(0, 99) < snk_stall_pct) begin
			stall_left = $urandom_range(1, 8) - 1;
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= 1'b1;
		end
	end

	// watchdog: too long with no beat moving on either side
	initial begin
		do @(negedge clk); while (quiet_cycles < WATCHDOG_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_beat(beat_op_e op, logic [7:0] d, logic l);
		prog_beat_t b;
		b.op   = op;
		b.data = d;
		b.last = l;
		pending_beats.push_back(b);
		beats_queued++;
	endtask

	task automatic push_ticks(int n);
		repeat (n) push_beat(OP_TICK, 8'($urandom), 1'($urandom));
	endtask

	// wait until every queued beat is taken and every result is back
	task automatic drain();
		while (beats_taken != beats_queued || line_results_due.size() != 0)
			@(negedge clk);
	endtask

	// finish any transmission still running so the block is idle
	task automatic settle();
		int frames_left;
		drain();
		while (tx_active) begin
			frames_left = int'(held_count) - int'(send_idx);
			push_ticks(frames_left * FRAME_BITS * ((bit_ticks == 0) ? 1 : int'(bit_ticks)));
			drain();
		end
		repeat (3) @(negedge clk);
	endtask

	// apb read of the bit time, compared with the value expected
	task automatic check_bit_ticks(logic [TPB_W-1:0] v);
		logic [PDATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= TPB_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== PDATA_W'(v))
			report_mismatch($sformatf("ticks_per_bit reads %0h, expected %0h", rd, v));
	endtask

	// apb write of the bit time, then read it back
	task automatic program_bit_ticks(logic [TPB_W-1:0] v);
		logic [PDATA_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TPB_ADDR;
		pwdata  <= PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		bit_ticks = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== PDATA_W'(v))
			report_mismatch($sformatf("ticks_per_bit reads %0h, wrote %0h", rd, v));
	endtask

	// one program: a few idle ticks, loads, then the ticks to send it,
	// now and then with the last flag early, missing, or the ticks cut short
	task automatic queue_program(int n_loads, inout int beat_sum);
		int last_at;
		int span;
		int n_ticks;
		push_ticks($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: last_at = -1;
			1: last_at = $urandom_range(0, n_loads - 1);
			default: last_at = n_loads - 1;
		endcase
		for (int i = 0; i < n_loads; i++) begin
			if (i < last_at)
				push_beat(OP_LOAD, 8'($urandom), 1'b0);
			else if (i == last_at)
				push_beat(OP_LOAD, 8'($urandom), 1'b1);
			else
				push_beat(OP_LOAD, 8'($urandom), 1'($urandom));
		end
		span = ((n_loads > MAX_BYTES) ? MAX_BYTES : n_loads) * FRAME_BITS *
			((bit_ticks == 0) ? 1 : int'(bit_ticks));
		n_ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, span) :
			span + $urandom_range(0, 6);
		// stray loads among the ticks
		for (int i = 0; i < n_ticks; i++) begin
			if ($urandom_range(0, 99) < 4)
				push_beat(OP_LOAD, 8'($urandom), 1'($urandom));
			else
				push_beat(OP_TICK, 8'($urandom), 1'($urandom));
		end
		beat_sum += n_loads + n_ticks;
	endtask

	// stimulus
	initial begin
		int beat_sum;
		int n_loads;
		bit first_program;
		logic [TPB_W-1:0] tpb;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset bit time reads back, ticks while idle change nothing
		check_bit_ticks(TPB_RESET);
		push_beat(OP_TICK, 8'hFF, 1'b1);
		push_beat(OP_TICK, 8'h00, 1'b0);
		settle();

		// fastest bit time, byte extremes, a late load dropped
		program_bit_ticks(16'd1);
		push_beat(OP_LOAD, 8'h00, 1'b0);
		push_beat(OP_LOAD, 8'hFF, 1'b0);
		push_beat(OP_LOAD, 8'h80, 1'b1);
		push_beat(OP_LOAD, 8'h7E, 1'b1);
		settle();

		// fill the buffer, overflow, and start the send from a dropped last byte
		for (int i = 0; i < MAX_BYTES; i++)
			push_beat(OP_LOAD, 8'(i * 17), 1'b0);
		push_beat(OP_LOAD, 8'h5A, 1'b0);
		push_beat(OP_LOAD, 8'hC3, 1'b1);
		settle();

		// zero bit time advances on every tick
		program_bit_ticks(16'd0);
		push_beat(OP_LOAD, 8'h01, 1'b1);
		settle();

		// slowest bit time while bytes are held, sent later at a short bit time
		program_bit_ticks(16'hFFFF);
		push_beat(OP_LOAD, 8'h55, 1'b0);
		push_beat(OP_TICK, 8'h0F, 1'b0);
		settle();
		program_bit_ticks(16'd2);
		push_beat(OP_LOAD, 8'hAA, 1'b1);
		settle();

		// random phases, each with its own bit time and idling mix
		beat_sum      = 0;
		first_program = 1'b1;
		while (beat_sum < RANDOM_BEATS) begin
			case ($urandom_range(0, 9))
				0: tpb = 16'd0;
				1: tpb = TPB_W'($urandom_range(5, 12));
				2: tpb = 16'd1;
				default: tpb = TPB_W'($urandom_range(1, 4));
			endcase
			program_bit_ticks(tpb);
			// last part of the run runs flat out
			if (beat_sum >= RANDOM_BEATS * 4 / 5) begin
				src_gap_pct   = 0;
				snk_stall_pct = 0;
			end else begin
				src_gap_pct   = $urandom_range(0, 1) * 25;
				snk_stall_pct = $urandom_range(0, 1) * 25;
			end
			repeat ($urandom_range(2, 4)) begin
				if (bit_ticks <= 1 && $urandom_range(0, 9) == 0)
					n_loads = $urandom_range(MAX_BYTES, MAX_BYTES + 3);
				else
					n_loads = $urandom_range(1, 4);
				queue_program(n_loads, beat_sum);
				// receiver holds off while the sender keeps offering beats
				if (first_program) begin
					hold_request  = 1'b1;
					first_program = 1'b0;
				end
			end
			settle();
		end

		drain();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
